>>> sv/mcd_pkg.sv
// Shared types and constants for the microcoded datapath step block.
`timescale 1ns / 1ps

package mcd_pkg;

    localparam int DATA_W          = 32;
    localparam int REG_IDX_W       = 4;
    localparam int REG_COUNT       = 16;
    localparam int CODE_W          = 13;
    localparam int HOST_ADDR_W     = 10;
    localparam int MEM_WORDS_DEF   = 1024;
    localparam int RETURN_REG_DEF  = 15;

    typedef enum logic [1:0] {
        KIND_EXEC   = 2'd0,
        KIND_MEM_WR = 2'd1,
        KIND_MEM_RD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_NAND = 2'd1,
        ALU_SUB  = 2'd2
    } alu_op_t;

    // microstep control codes
    localparam logic [CODE_W-1:0] CODE_A_RY    = 13'd1088;
    localparam logic [CODE_W-1:0] CODE_B_RX    = 13'd1057;
    localparam logic [CODE_W-1:0] CODE_B_RZ    = 13'd1056;
    localparam logic [CODE_W-1:0] CODE_B_IMM   = 13'd288;
    localparam logic [CODE_W-1:0] CODE_ALU_WB  = 13'd2049;
    localparam logic [CODE_W-1:0] CODE_ALU_ADD = 13'd2064;
    localparam logic [CODE_W-1:0] CODE_LOAD    = 13'd513;
    localparam logic [CODE_W-1:0] CODE_STORE   = 13'd1026;
    localparam logic [CODE_W-1:0] CODE_BEQ     = 13'd2052;
    localparam logic [CODE_W-1:0] CODE_A_PC    = 13'd4160;
    localparam logic [CODE_W-1:0] CODE_PC_ADD  = 13'd2176;
    localparam logic [CODE_W-1:0] CODE_SAVE_RA = 13'd4097;
    localparam logic [CODE_W-1:0] CODE_PC_RX   = 13'd1152;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

endpackage

>>> sv/mcd_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module mcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mcd_alu.sv
// ALU of the datapath: add, nand or subtract of the two operand latches.
`timescale 1ns / 1ps

module mcd_alu (
    input  mcd_pkg::alu_op_t              op,
    input  logic [mcd_pkg::DATA_W-1:0]    a,
    input  logic [mcd_pkg::DATA_W-1:0]    b,
    output logic [mcd_pkg::DATA_W-1:0]    y
);

    always_comb begin
        case (op)
            mcd_pkg::ALU_NAND: y = ~(a & b);
            mcd_pkg::ALU_SUB:  y = a - b;
            default:           y = a + b;   // unused selector adds too
        endcase
    end

endmodule

>>> sv/mcd_regfile.sv
// 16-entry register file with load writeback port and bypass on the read port.
`timescale 1ns / 1ps

module mcd_regfile (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcd_pkg::rf_wr_t                 ld_wr,   // late load data, older item
    input  mcd_pkg::rf_wr_t                 ex_wr,   // current item
    input  logic [mcd_pkg::REG_IDX_W-1:0]   raddr,
    output logic [mcd_pkg::DATA_W-1:0]      rdata
);

    logic [mcd_pkg::DATA_W-1:0] regs_reg [mcd_pkg::REG_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mcd_pkg::REG_COUNT; i++) begin
                regs_reg[i] <= '0;
            end
        end else begin
            if (ld_wr.en) begin
                regs_reg[ld_wr.idx] <= ld_wr.data;
            end
            // younger item wins on a clash
            if (ex_wr.en) begin
                regs_reg[ex_wr.idx] <= ex_wr.data;
            end
        end
    end

    assign rdata = (ld_wr.en && ld_wr.idx == raddr) ? ld_wr.data : regs_reg[raddr];

endmodule

>>> sv/microcoded_cpu_datapath_step.sv
// Top level of the microcoded datapath step: item register, execute, result register.
//
//  channel  | ports                      | contents
//  ---------+----------------------------+-------------------------------------------
//  input    | s_tvalid s_tready s_tdata  | microstep or host memory access,
//           | s_tuser                    | kind in tuser
//  result   | m_tvalid m_tready m_tdata  | stop flag, PC, host read word
//
//  One item per cycle sustained while the result side is ready; an accepted item
//  moves from stage one to the result register, from which its result is taken.
//  Stage one holds the accepted item, the state updates as it moves to the result
//  register; the memory read lands there, load data is written back in the next cycle
//  and bypassed to the next item. Synchronous active-low reset clears registers,
//  operand latches and PC; memory contents are not cleared. A stalled result holds
//  both stages. MEM_WORDS must be a power of two.
`timescale 1ns / 1ps

module microcoded_cpu_datapath_step #(
    parameter int MEM_WORDS        = mcd_pkg::MEM_WORDS_DEF,
    parameter int RETURN_REG_INDEX = mcd_pkg::RETURN_REG_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] control_code, [44:13] instruction, [46:45] alu_op,
    // [56:47] mem_address, [88:57] mem_data
    input  logic [95:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] stop_chain, [32:1] pc_value, [64:33] read_data
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int DW = mcd_pkg::DATA_W;
    localparam int RW = mcd_pkg::REG_IDX_W;

    localparam logic [mcd_pkg::CODE_W-1:0] CODE_A_RY_SEL = mcd_pkg::CODE_A_RY;
    localparam logic [mcd_pkg::CODE_W-1:0] CODE_B_RZ_SEL = mcd_pkg::CODE_B_RZ;

    // stage one: accepted item
    logic                               s1_valid_reg;
    mcd_pkg::kind_t                     s1_kind_reg;
    logic [mcd_pkg::CODE_W-1:0]         s1_code_reg;
    logic [DW-1:0]                      s1_ins_reg;
    mcd_pkg::alu_op_t                   s1_op_reg;
    logic [mcd_pkg::HOST_ADDR_W-1:0]    s1_maddr_reg;
    logic [DW-1:0]                      s1_mdata_reg;

    // architectural latches
    logic [DW-1:0] a_reg, b_reg, res_reg, pc_reg;
    logic [DW-1:0] a_next, b_next, res_next, pc_next;

    // result stage
    logic          s2_valid_reg;
    logic          stop_reg, stop_next;
    logic          rd_sel_reg, rd_sel_next;
    logic          ld_pend_reg, ld_next;
    logic [RW-1:0] ld_idx_reg;

    logic s_acc, adv;

    logic [RW-1:0] rx, ry, rz, rf_raddr;
    logic [DW-1:0] rf_rdata, alu_y, imm_ext, ram_q, host_addr_ext;
    logic [AW-1:0] res_idx, host_idx, ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_we, ram_re;
    mcd_pkg::rf_wr_t ex_wr, ld_wr;

    assign adv      = s1_valid_reg && (!s2_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    assign rx       = s1_ins_reg[27:24];
    assign ry       = s1_ins_reg[23:20];
    assign rz       = s1_ins_reg[19:16];
    assign imm_ext  = {{(DW-16){s1_ins_reg[15]}}, s1_ins_reg[15:0]};

    assign host_addr_ext = {{(DW-mcd_pkg::HOST_ADDR_W){1'b0}}, s1_maddr_reg};
    assign res_idx       = res_reg[AW-1:0];
    assign host_idx      = host_addr_ext[AW-1:0];

    always_comb begin
        case (s1_code_reg)
            CODE_A_RY_SEL: rf_raddr = ry;
            CODE_B_RZ_SEL: rf_raddr = rz;
            default:       rf_raddr = rx;
        endcase
    end

    assign ld_wr.en   = ld_pend_reg;
    assign ld_wr.idx  = ld_idx_reg;
    assign ld_wr.data = ram_q;

    mcd_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld_wr   (ld_wr),
        .ex_wr   (ex_wr),
        .raddr   (rf_raddr),
        .rdata   (rf_rdata)
    );

    mcd_alu u_alu (
        .op (s1_op_reg),
        .a  (a_reg),
        .b  (b_reg),
        .y  (alu_y)
    );

    mcd_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // execute: state updates for the item in stage one
    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        pc_next     = pc_reg;
        stop_next   = 1'b0;
        rd_sel_next = 1'b0;
        ld_next     = 1'b0;
        ex_wr.en    = 1'b0;
        ex_wr.idx   = rx;
        ex_wr.data  = alu_y;
        ram_we      = 1'b0;
        ram_waddr   = res_idx;
        ram_wdata   = rf_rdata;
        ram_raddr   = res_idx;
        case (s1_kind_reg)
            mcd_pkg::KIND_EXEC: begin
                case (s1_code_reg)
                    mcd_pkg::CODE_A_RY:    a_next = rf_rdata;
                    mcd_pkg::CODE_B_RX:    b_next = rf_rdata;
                    mcd_pkg::CODE_B_RZ:    b_next = rf_rdata;
                    mcd_pkg::CODE_B_IMM:   b_next = imm_ext;
                    mcd_pkg::CODE_ALU_WB: begin
                        res_next = alu_y;
                        ex_wr.en = 1'b1;
                    end
                    mcd_pkg::CODE_ALU_ADD: res_next = a_reg + b_reg;
                    mcd_pkg::CODE_LOAD:    ld_next = 1'b1;
                    mcd_pkg::CODE_STORE:   ram_we = 1'b1;
                    mcd_pkg::CODE_BEQ:     stop_next = (b_reg != a_reg);
                    mcd_pkg::CODE_A_PC:    a_next = pc_reg;
                    mcd_pkg::CODE_PC_ADD:  pc_next = a_reg + b_reg;
                    mcd_pkg::CODE_SAVE_RA: begin
                        ex_wr.en   = 1'b1;
                        ex_wr.idx  = RW'(RETURN_REG_INDEX);
                        ex_wr.data = pc_reg;
                    end
                    mcd_pkg::CODE_PC_RX:   pc_next = rf_rdata;
                    default: ;  // halt and unknown codes
                endcase
            end
            mcd_pkg::KIND_MEM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = host_idx;
                ram_wdata = s1_mdata_reg;
            end
            mcd_pkg::KIND_MEM_RD: begin
                rd_sel_next = 1'b1;
                ram_raddr   = host_idx;
            end
            default: ;
        endcase
        ex_wr.en = ex_wr.en && adv;
        ram_we   = ram_we && adv;
    end

    assign ram_re = adv && (ld_next || rd_sel_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ld_pend_reg  <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            res_reg      <= '0;
            pc_reg       <= '0;
        end else begin
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                s2_valid_reg <= 1'b1;
            end else if (m_tready) begin
                s2_valid_reg <= 1'b0;
            end
            ld_pend_reg <= adv && ld_next;
            if (adv) begin
                a_reg   <= a_next;
                b_reg   <= b_next;
                res_reg <= res_next;
                pc_reg  <= pc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_kind_reg  <= mcd_pkg::kind_t'(s_tuser);
            s1_code_reg  <= s_tdata[12:0];
            s1_ins_reg   <= s_tdata[44:13];
            s1_op_reg    <= mcd_pkg::alu_op_t'(s_tdata[46:45]);
            s1_maddr_reg <= s_tdata[56:47];
            s1_mdata_reg <= s_tdata[88:57];
        end
        if (adv) begin
            stop_reg   <= stop_next;
            rd_sel_reg <= rd_sel_next;
            ld_idx_reg <= rx;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {7'd0, (rd_sel_reg ? ram_q : {DW{1'b0}}), pc_reg, stop_reg};

    // a pending load writeback always belongs to the item in the result register
    a_ld_in_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_pend_reg |-> s2_valid_reg)
        else $error("load writeback pending without its item");

    // latches only move when an item leaves stage one
    a_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pc_reg) && $stable(res_reg))
        else $error("PC or ALU result changed without an item");

    // host read data only shows for a read item
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !rd_sel_reg |-> m_tdata[64:33] == '0)
        else $error("read data on a non-read item");

    // an empty input stage always takes an item
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the microcoded datapath step block.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0]                KIND_NONE   = 2'd3;
    localparam logic [1:0]                ALU_SPARE   = 2'd3;
    localparam logic [mcd_pkg::CODE_W-1:0] CODE_HALT  = 13'd3;
    localparam logic [mcd_pkg::CODE_W-1:0] CODE_TOP   = 13'h1FFF;
    localparam int                        CYCLE_LIMIT = 500000;

    typedef struct {
        logic [1:0]                      kind;
        logic [mcd_pkg::CODE_W-1:0]      code;
        logic [mcd_pkg::DATA_W-1:0]      ins;
        logic [1:0]                      op;
        logic [mcd_pkg::HOST_ADDR_W-1:0] maddr;
        logic [mcd_pkg::DATA_W-1:0]      mdata;
    } step_item_t;

    typedef struct packed {
        logic                       stop;
        logic [mcd_pkg::DATA_W-1:0] pc;
        logic [mcd_pkg::DATA_W-1:0] rdata;
    } step_outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    // datapath image kept alongside the block
    bit [mcd_pkg::DATA_W-1:0] rf [mcd_pkg::REG_COUNT];
    bit [mcd_pkg::DATA_W-1:0] op_a, op_b, alu_res, pc_reg;
    bit [mcd_pkg::DATA_W-1:0] mem_img [mcd_pkg::MEM_WORDS_DEF];
    bit                       mem_valid [mcd_pkg::MEM_WORDS_DEF];

    step_outcome_t step_outcomes[$];
    step_outcome_t want;
    int            mismatches = 0;
    int            items_sent = 0;
    int            idle_pct = 20;
    int            cycles = 0;
    bit            tx_active = 1'b0;

    microcoded_cpu_datapath_step i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic step_outcome_t run_step(step_item_t it);
        step_outcome_t o;
        logic [mcd_pkg::REG_IDX_W-1:0] rx, ry, rz;
        rx = it.ins[27:24];
        ry = it.ins[23:20];
        rz = it.ins[19:16];
        o  = '0;
        if (it.kind == mcd_pkg::KIND_EXEC) begin
            case (it.code)
                mcd_pkg::CODE_A_RY:    op_a = rf[ry];
                mcd_pkg::CODE_B_RX:    op_b = rf[rx];
                mcd_pkg::CODE_B_RZ:    op_b = rf[rz];
                mcd_pkg::CODE_B_IMM:   op_b = {{16{it.ins[15]}}, it.ins[15:0]};
                mcd_pkg::CODE_ALU_WB: begin
                    case (it.op)
                        mcd_pkg::ALU_NAND: alu_res = ~(op_a & op_b);
                        mcd_pkg::ALU_SUB:  alu_res = op_a - op_b;
                        default:           alu_res = op_a + op_b;
                    endcase
                    rf[rx] = alu_res;
                end
                mcd_pkg::CODE_ALU_ADD: alu_res = op_a + op_b;
                mcd_pkg::CODE_LOAD:    rf[rx] = mem_img[alu_res[mcd_pkg::HOST_ADDR_W-1:0]];
                mcd_pkg::CODE_STORE: begin
                    mem_img[alu_res[mcd_pkg::HOST_ADDR_W-1:0]]   = rf[rx];
                    mem_valid[alu_res[mcd_pkg::HOST_ADDR_W-1:0]] = 1'b1;
                end
                mcd_pkg::CODE_BEQ:     o.stop = (op_b - op_a) != 0;
                mcd_pkg::CODE_A_PC:    op_a = pc_reg;
                mcd_pkg::CODE_PC_ADD:  pc_reg = op_a + op_b;
                mcd_pkg::CODE_SAVE_RA: rf[mcd_pkg::RETURN_REG_DEF] = pc_reg;
                mcd_pkg::CODE_PC_RX:   pc_reg = rf[rx];
                default: ;
            endcase
        end else if (it.kind == mcd_pkg::KIND_MEM_WR) begin
            mem_img[it.maddr]   = it.mdata;
            mem_valid[it.maddr] = 1'b1;
        end else if (it.kind == mcd_pkg::KIND_MEM_RD) begin
            o.rdata = mem_img[it.maddr];
        end
        o.pc = pc_reg;
        return o;
    endfunction

    function automatic void check_field(string what, logic [mcd_pkg::DATA_W-1:0] exp_v,
                                        logic [mcd_pkg::DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (step_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = step_outcomes.pop_front();
                check_field("stop_chain", {31'd0, want.stop}, {31'd0, m_tdata[0]});
                check_field("pc_value", want.pc, m_tdata[32:1]);
                check_field("read_data", want.rdata, m_tdata[64:33]);
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [mcd_pkg::DATA_W-1:0] make_ins(logic [3:0] rx, logic [3:0] ry,
                                                           logic [3:0] rz, logic [15:0] imm);
        logic [mcd_pkg::DATA_W-1:0] r;
        r = $urandom;
        return {r[3:0], rx, ry, rz, imm};
    endfunction

    function automatic step_item_t micro(logic [mcd_pkg::CODE_W-1:0] code,
                                         logic [mcd_pkg::DATA_W-1:0] ins,
                                         logic [1:0] op);
        step_item_t it;
        logic [mcd_pkg::DATA_W-1:0] r;
        r        = $urandom;
        it.kind  = mcd_pkg::KIND_EXEC;
        it.code  = code;
        it.ins   = ins;
        it.op    = op;
        it.maddr = r[mcd_pkg::HOST_ADDR_W-1:0];
        it.mdata = $urandom;
        return it;
    endfunction

    function automatic step_item_t host(logic [1:0] kind,
                                        logic [mcd_pkg::HOST_ADDR_W-1:0] addr,
                                        logic [mcd_pkg::DATA_W-1:0] data);
        step_item_t it;
        logic [mcd_pkg::DATA_W-1:0] r;
        r        = $urandom;
        it.kind  = kind;
        it.code  = r[mcd_pkg::CODE_W-1:0];
        it.ins   = $urandom;
        it.op    = r[31:30];
        it.maddr = addr;
        it.mdata = data;
        return it;
    endfunction

    // expects to be entered just after a rising edge
    task automatic send_raw(input step_item_t it);
        s_tvalid  <= 1'b1;
        s_tdata   <= {7'd0, it.mdata, it.maddr, it.op, it.ins, it.code};
        s_tuser   <= it.kind;
        tx_active  = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_outcomes.push_back(run_step(it));
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid  <= 1'b0;
            tx_active  = 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // a word that was never written is filled by the host before anything reads it
    task automatic send_item(input step_item_t it);
        logic [mcd_pkg::HOST_ADDR_W-1:0] addr;
        bit                              reads;
        reads = 1'b0;
        addr  = it.maddr;
        if (it.kind == mcd_pkg::KIND_MEM_RD) begin
            reads = 1'b1;
        end else if (it.kind == mcd_pkg::KIND_EXEC && it.code == mcd_pkg::CODE_LOAD) begin
            reads = 1'b1;
            addr  = alu_res[mcd_pkg::HOST_ADDR_W-1:0];
        end
        if (reads && !mem_valid[addr]) begin
            send_raw(host(mcd_pkg::KIND_MEM_WR, addr, $urandom));
        end
        send_raw(it);
    endtask

    task automatic wait_results();
        if (tx_active) begin
            s_tvalid  <= 1'b0;
            tx_active  = 1'b0;
        end
        while (step_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_host_memory();
        send_item(host(mcd_pkg::KIND_MEM_WR, 10'd0, 32'hFFFF_FFFF));
        send_item(host(mcd_pkg::KIND_MEM_WR, 10'd1023, 32'h0000_0000));
        send_item(host(mcd_pkg::KIND_MEM_RD, 10'd0, $urandom));
        send_item(host(mcd_pkg::KIND_MEM_RD, 10'd1023, $urandom));
        send_item(host(KIND_NONE, 10'd1023, 32'hFFFF_FFFF));
    endtask

    task automatic test_microsteps();
        send_item(micro(mcd_pkg::CODE_A_RY, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_B_IMM, make_ins(4'd0, 4'd0, 4'd0, 16'h7FFF),
                        mcd_pkg::ALU_ADD));
        // register zero takes writes here
        send_item(micro(mcd_pkg::CODE_ALU_WB, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_A_RY, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_B_IMM, make_ins(4'd0, 4'd0, 4'd0, 16'h8000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_ALU_WB, make_ins(4'd1, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_NAND));
        send_item(micro(mcd_pkg::CODE_B_RZ, make_ins(4'd0, 4'd0, 4'd1, 16'hFFFF),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_ALU_WB, make_ins(4'd2, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_SUB));
        send_item(micro(mcd_pkg::CODE_ALU_WB, make_ins(4'd3, 4'd0, 4'd0, 16'h0000),
                        ALU_SPARE));
        // sum wraps past the top of memory
        send_item(micro(mcd_pkg::CODE_ALU_ADD, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_STORE, make_ins(4'd1, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_LOAD, make_ins(4'd4, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(CODE_HALT, make_ins(4'd15, 4'd15, 4'd15, 16'hFFFF),
                        mcd_pkg::ALU_ADD));
        send_item(micro(CODE_TOP, make_ins(4'd15, 4'd15, 4'd15, 16'hFFFF), ALU_SPARE));
    endtask

    task automatic test_branch_and_jump();
        send_item(micro(mcd_pkg::CODE_BEQ, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_A_PC, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_B_IMM, make_ins(4'd0, 4'd0, 4'd0, 16'h0010),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_PC_ADD, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_SAVE_RA, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_PC_RX, make_ins(4'd2, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_A_RY, make_ins(4'd0, 4'd5, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_B_RX, make_ins(4'd5, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
        send_item(micro(mcd_pkg::CODE_BEQ, make_ins(4'd0, 4'd0, 4'd0, 16'h0000),
                        mcd_pkg::ALU_ADD));
    endtask

    // mostly whole instructions as microstep chains, some noise and host traffic
    task automatic run_programs(input int count, input bit vary_idle);
        logic [mcd_pkg::DATA_W-1:0]      r;
        logic [mcd_pkg::DATA_W-1:0]      ins;
        logic [mcd_pkg::DATA_W-1:0]      last_sw_ins;
        logic [mcd_pkg::HOST_ADDR_W-1:0] last_addr;
        logic [3:0]                      rx, ry, rz;
        logic [15:0]                     imm;
        logic [1:0]                      op;
        bit                              have_sw;
        int                              stop_at, next_chunk, next_drain;
        step_item_t                      it;
        have_sw     = 1'b0;
        last_sw_ins = '0;
        last_addr   = '0;
        stop_at     = items_sent + count;
        next_chunk  = items_sent;
        next_drain  = items_sent + 400;
        if (!vary_idle) idle_pct = 0;
        while (items_sent < stop_at) begin
            if (vary_idle && items_sent >= next_chunk) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
                next_chunk = items_sent + 100;
            end
            if (vary_idle && items_sent >= next_drain) begin
                wait_results();
                next_drain = items_sent + 400;
            end
            r   = $urandom;
            rx  = r[3:0];
            ry  = r[7:4];
            rz  = r[11:8];
            op  = r[13:12];
            if (r[15:14] == 2'd0) begin
                imm = r[31:16];
            end else begin
                r   = $urandom_range(0, 63) - 32;
                imm = r[15:0];
            end
            ins = make_ins(rx, ry, rz, imm);
            case ($urandom_range(0, 11))
                0, 1: begin
                    send_item(micro(mcd_pkg::CODE_A_RY, ins, op));
                    send_item(micro(mcd_pkg::CODE_B_RZ, ins, op));
                    send_item(micro(mcd_pkg::CODE_ALU_WB, ins, op));
                end
                2, 3: begin
                    send_item(micro(mcd_pkg::CODE_A_RY, ins, op));
                    send_item(micro(mcd_pkg::CODE_B_IMM, ins, op));
                    send_item(micro(mcd_pkg::CODE_ALU_WB, ins, mcd_pkg::ALU_ADD));
                end
                4: begin
                    if (have_sw && $urandom_range(0, 1) == 1) ins = last_sw_ins;
                    send_item(micro(mcd_pkg::CODE_A_RY, ins, op));
                    send_item(micro(mcd_pkg::CODE_B_IMM, ins, op));
                    send_item(micro(mcd_pkg::CODE_ALU_ADD, ins, op));
                    send_item(micro(mcd_pkg::CODE_LOAD, ins, op));
                end
                5: begin
                    send_item(micro(mcd_pkg::CODE_A_RY, ins, op));
                    send_item(micro(mcd_pkg::CODE_B_IMM, ins, op));
                    send_item(micro(mcd_pkg::CODE_ALU_ADD, ins, op));
                    send_item(micro(mcd_pkg::CODE_STORE, ins, op));
                    last_sw_ins = ins;
                    have_sw     = 1'b1;
                end
                6, 7: begin
                    if ($urandom_range(0, 1) == 1) ins[27:24] = ins[23:20];
                    send_item(micro(mcd_pkg::CODE_A_RY, ins, op));
                    send_item(micro(mcd_pkg::CODE_B_RX, ins, op));
                    send_item(micro(mcd_pkg::CODE_BEQ, ins, op));
                    // equal operands: continue the chain and take the branch
                    if (op_a == op_b) begin
                        send_item(micro(mcd_pkg::CODE_A_PC, ins, op));
                        send_item(micro(mcd_pkg::CODE_B_IMM, ins, op));
                        send_item(micro(mcd_pkg::CODE_PC_ADD, ins, op));
                    end
                end
                8: begin
                    send_item(micro(mcd_pkg::CODE_SAVE_RA, ins, op));
                    send_item(micro(mcd_pkg::CODE_PC_RX, ins, op));
                end
                9: begin
                    r        = $urandom;
                    it.kind  = r[1:0];
                    it.code  = r[14:2];
                    it.op    = r[16:15];
                    it.maddr = r[26:17];
                    it.ins   = $urandom;
                    it.mdata = $urandom;
                    send_item(it);
                end
                10: begin
                    r = $urandom;
                    if (r[0]) begin
                        last_addr = r[10:1];
                        send_item(host(mcd_pkg::KIND_MEM_WR, last_addr, $urandom));
                    end else if (r[1]) begin
                        send_item(host(mcd_pkg::KIND_MEM_RD, last_addr, $urandom));
                    end else begin
                        send_item(host(mcd_pkg::KIND_MEM_RD, r[11:2], $urandom));
                    end
                end
                default: begin
                    send_item(micro($urandom_range(0, 1) == 1 ? CODE_HALT : r[28:16], ins, op));
                end
            endcase
        end
    endtask

    task automatic test_random_programs();
        run_programs(1450, 1'b1);
        wait_results();
    endtask

    task automatic test_steady_stream();
        run_programs(250, 1'b0);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_host_memory();
        test_microsteps();
        test_branch_and_jump();
        wait_results();
        test_random_programs();
        test_steady_stream();

        wait_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
